FILE: hdl/mts_pkg.sv
package mts_pkg;

    localparam int unsigned DATA_W = 32;
    localparam int unsigned OCC_W  = 9;
    localparam logic signed [DATA_W-1:0] INT_MAX = 32'sh7FFF_FFFF;

    typedef enum logic [1:0] {
        REQ_PUSH  = 2'd0,
        REQ_POP   = 2'd1,
        REQ_QUERY = 2'd2,
        REQ_SPARE = 2'd3
    } req_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_UNDERFLOW = 2'd1,
        ST_OVERFLOW  = 2'd2
    } status_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] value;
        logic signed [DATA_W-1:0] run_min;
    } entry_t;

    typedef struct packed {
        logic push;
        logic pop;
    } shift_t;

endpackage

FILE: hdl/mts_cell.sv
module mts_cell (
    input  logic            clk,
    input  mts_pkg::shift_t shift,
    input  mts_pkg::entry_t from_above,
    input  mts_pkg::entry_t from_below,
    output mts_pkg::entry_t entry
);
    import mts_pkg::*;

    entry_t entry_reg;
    entry_t entry_next;

    always_comb
    begin
        entry_next = entry_reg;
        if (shift.push)
        begin
            entry_next = from_above;
        end
        else if (shift.pop)
        begin
            entry_next = from_below;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;

endmodule

FILE: hdl/min_tracking_stack_unit.sv
// Bounded stack of signed 32-bit values that also reports the minimum of all
// entries held. The stack is a row of STACK_DEPTH cells with the top in the
// first cell; a push shifts every cell down by one and a pop shifts every cell
// up by one, so each request only ever looks at the first two cells. A request
// is accepted in any cycle in which the output register is empty or its result
// transfer is taken in that same cycle. The result transfer is offered from the
// cycle after the request is accepted. While the receiver keeps up, requests can
// follow one per cycle. While it stalls, the waiting result holds off the next
// request. A pop on an empty stack reports underflow and a push on a full stack
// reports overflow; neither changes the contents.
module min_tracking_stack_unit #(
    parameter int unsigned STACK_DEPTH = 256
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // push_value
    input  logic [1:0]  s_axis_tuser,   // req_type
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [79:0] m_axis_tdata,   // min_value, top_value, occupancy, is_empty, zero pad
    output logic [1:0]  m_axis_tuser    // status
);
    import mts_pkg::*;

    localparam int unsigned CNT_W = $clog2(STACK_DEPTH + 1);
    localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(STACK_DEPTH);

    entry_t cell_q [STACK_DEPTH];
    shift_t shift;
    entry_t new_entry;

    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             out_valid_reg;
    logic [1:0]       status_reg;
    logic signed [DATA_W-1:0] min_reg;
    logic signed [DATA_W-1:0] top_reg;
    logic [OCC_W-1:0] occ_reg;
    logic             empty_reg;

    logic             accept;
    logic             is_full;
    logic             is_zero;
    req_t             req;
    logic signed [DATA_W-1:0] push_val;
    status_t          status_next;
    logic signed [DATA_W-1:0] min_next;
    logic signed [DATA_W-1:0] top_next;
    logic [CNT_W+OCC_W-1:0]   occ_ext;

    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign req           = req_t'(s_axis_tuser);
    assign push_val      = s_axis_tdata;
    assign is_full       = (count_reg == FULL_COUNT);
    assign is_zero       = (count_reg == '0);

    always_comb
    begin
        new_entry.value   = push_val;
        new_entry.run_min = (is_zero || push_val < cell_q[0].run_min)
                            ? push_val : cell_q[0].run_min;
        shift       = '0;
        status_next = ST_OK;
        count_next  = count_reg;
        min_next    = is_zero ? INT_MAX : cell_q[0].run_min;
        top_next    = is_zero ? '0 : cell_q[0].value;
        case (req)
            REQ_PUSH:
            begin
                if (is_full)
                begin
                    status_next = ST_OVERFLOW;
                end
                else
                begin
                    shift.push = accept;
                    count_next = count_reg + 1'b1;
                    min_next   = new_entry.run_min;
                    top_next   = push_val;
                end
            end
            REQ_POP:
            begin
                if (is_zero)
                begin
                    status_next = ST_UNDERFLOW;
                end
                else
                begin
                    shift.pop  = accept;
                    count_next = count_reg - 1'b1;
                    if (count_reg == CNT_W'(1))
                    begin
                        min_next = INT_MAX;
                        top_next = '0;
                    end
                    else
                    begin
                        min_next = cell_q[1].run_min;
                        top_next = cell_q[1].value;
                    end
                end
            end
            default:
            begin
                status_next = ST_OK;
            end
        endcase
        occ_ext = {{OCC_W{1'b0}}, count_next};
    end

    for (genvar i = 0; i < STACK_DEPTH; i++)
    begin : g_row
        entry_t above;
        entry_t below;
        if (i == 0)
        begin : g_first
            assign above = new_entry;
        end
        else
        begin : g_mid
            assign above = cell_q[i-1];
        end
        if (i == STACK_DEPTH - 1)
        begin : g_last
            assign below = cell_q[i];
        end
        else
        begin : g_inner
            assign below = cell_q[i+1];
        end
        mts_cell u_cell (
            .clk        (clk),
            .shift      (shift),
            .from_above (above),
            .from_below (below),
            .entry      (cell_q[i])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                count_reg     <= count_next;
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            status_reg <= status_next;
            min_reg    <= min_next;
            top_reg    <= top_next;
            occ_reg    <= occ_ext[OCC_W-1:0];
            empty_reg  <= (count_next == '0);
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = status_reg;
    assign m_axis_tdata  = {6'b0, empty_reg, occ_reg, top_reg, min_reg};

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FULL_COUNT)
        else $error("entry count exceeds stack depth");

    a_overflow_hold: assert property (@(posedge clk) disable iff (!rst_n)
        accept && req == REQ_PUSH && is_full |=> $stable(count_reg))
        else $error("overflowing push changed the entry count");

    a_empty_result: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && empty_reg |-> min_reg == INT_MAX && top_reg == '0)
        else $error("empty result carries a minimum or top value");

    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> m_axis_tvalid)
        else $error("accepted request produced no result");

endmodule
